@@ src/frpm_pkg.sv @@
// ============================================================================
// frpm_pkg - shared types and constants of the fault rate pressure monitor
// Level codes, register indexes, reset values and the command word that
// travels from the front end through the queue to the back end.
// ============================================================================
package frpm_pkg;

   localparam int MEM_KB_W    = 24;
   localparam int LIMIT_W     = 26;
   localparam int THRESH_W    = 16;
   localparam int FAULT_W     = 32;
   localparam int AVG_W       = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 26;

   localparam logic [CSR_INDEX_W-1:0] CSR_FREE_MEM_LIMIT     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRITICAL_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERY_LOW_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_THRESHOLD      = 2'd3;

   localparam logic [LIMIT_W-1:0]  RESET_FREE_MEM_LIMIT     = 26'd10000;
   localparam logic [THRESH_W-1:0] RESET_CRITICAL_THRESHOLD = 16'd250;
   localparam logic [THRESH_W-1:0] RESET_VERY_LOW_THRESHOLD = 16'd120;
   localparam logic [THRESH_W-1:0] RESET_LOW_THRESHOLD      = 16'd60;

   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = 2;

   typedef enum logic [2:0] {
      LEVEL_UNKNOWN  = 3'd0,
      LEVEL_CRITICAL = 3'd1,
      LEVEL_VERY_LOW = 3'd2,
      LEVEL_LOW      = 3'd3,
      LEVEL_NORMAL   = 3'd4
   } frpm_level_type;

   typedef struct packed {
      logic                      is_eval;
      logic                      ring_write;
      logic signed [FAULT_W-1:0] delta;
      logic                      slow_polling;
      logic                      poll_rate_changed;
   } frpm_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } frpm_qstat_type;

   typedef struct packed {
      logic [THRESH_W-1:0] critical;
      logic [THRESH_W-1:0] very_low;
      logic [THRESH_W-1:0] low;
   } frpm_thresh_type;

endpackage

@@ src/fault_rate_pressure_monitor.sv @@
// ============================================================================
// fault_rate_pressure_monitor - memory pressure monitor
// Tracks a moving average of page-fault deltas and turns it into a pressure
// level; also selects the poll interval from the free memory total.
// ============================================================================
// Usage:
//   Words enter on the req_ channel (valid/ready). mode 0 is a sample,
//   mode 1 asks for an evaluation of the windowed average. Every word gives
//   exactly one result word on the rsp_ channel, in order.
//   Thresholds and the free memory limit are written through the csr_ port
//   (write enable, index, data) while no word is in flight.
//   From acceptance to rsp_valid a word passes the queue entry, the NUM_ST
//   = ceil((32 + clog2(WINDOW_DEPTH)) / 8) stages of the long division of
//   the running sum by the depth, the sign restore and the result register.
//   One word is accepted every cycle while the queue is not full; the
//   division pipeline and the ring update set that rate.
//   When the receiver stalls, the result register holds and the back
//   pipeline freezes; the four-entry queue keeps req_ready high until full.
//   Reset clears the ring, the running sum and the previous fault count,
//   sets the level to unknown, selects slow polling and restores the
//   default register values.
// ============================================================================
module fault_rate_pressure_monitor #(
   parameter int WINDOW_DEPTH = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_mode,
   input  logic [frpm_pkg::MEM_KB_W-1:0]          req_mem_free_kb,
   input  logic [frpm_pkg::MEM_KB_W-1:0]          req_buffers_kb,
   input  logic [frpm_pkg::MEM_KB_W-1:0]          req_cached_kb,
   input  logic                                   req_mem_info_ok,
   input  logic [frpm_pkg::FAULT_W-1:0]           req_fault_reading,
   input  logic                                   req_fault_reading_ok,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [2:0]                             rsp_level,
   output logic                                   rsp_level_changed,
   output logic                                   rsp_slow_polling,
   output logic                                   rsp_poll_rate_changed,
   output logic signed [frpm_pkg::AVG_W-1:0]      rsp_average_faults,
   input  logic                                   csr_write_enable,
   input  logic [frpm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [frpm_pkg::CSR_DATA_W-1:0]        csr_data
);

   logic [frpm_pkg::LIMIT_W-1:0]  free_mem_limit_ff;
   frpm_pkg::frpm_thresh_type     thresh_ff;
   frpm_pkg::frpm_cmd_type        push_cmd, pop_cmd;
   frpm_pkg::frpm_qstat_type      queue_status;
   logic                          push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_mem_limit_ff  <= frpm_pkg::RESET_FREE_MEM_LIMIT;
         thresh_ff.critical <= frpm_pkg::RESET_CRITICAL_THRESHOLD;
         thresh_ff.very_low <= frpm_pkg::RESET_VERY_LOW_THRESHOLD;
         thresh_ff.low      <= frpm_pkg::RESET_LOW_THRESHOLD;
      end else if (csr_write_enable) begin
         case (csr_index)
            frpm_pkg::CSR_FREE_MEM_LIMIT: begin
               free_mem_limit_ff <= csr_data[frpm_pkg::LIMIT_W-1:0];
            end
            frpm_pkg::CSR_CRITICAL_THRESHOLD: begin
               thresh_ff.critical <= csr_data[frpm_pkg::THRESH_W-1:0];
            end
            frpm_pkg::CSR_VERY_LOW_THRESHOLD: begin
               thresh_ff.very_low <= csr_data[frpm_pkg::THRESH_W-1:0];
            end
            frpm_pkg::CSR_LOW_THRESHOLD: begin
               thresh_ff.low <= csr_data[frpm_pkg::THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   frpm_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_mem_free_kb      (req_mem_free_kb),
      .req_buffers_kb       (req_buffers_kb),
      .req_cached_kb        (req_cached_kb),
      .req_mem_info_ok      (req_mem_info_ok),
      .req_fault_reading    (req_fault_reading),
      .req_fault_reading_ok (req_fault_reading_ok),
      .free_mem_limit       (free_mem_limit_ff),
      .queue_status         (queue_status),
      .push                 (push),
      .push_cmd             (push_cmd)
   );

   frpm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (queue_status)
   );

   frpm_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .pop_cmd               (pop_cmd),
      .queue_status          (queue_status),
      .pop                   (pop),
      .thresholds            (thresh_ff),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_level             (rsp_level),
      .rsp_level_changed     (rsp_level_changed),
      .rsp_slow_polling      (rsp_slow_polling),
      .rsp_poll_rate_changed (rsp_poll_rate_changed),
      .rsp_average_faults    (rsp_average_faults)
   );

endmodule

@@ src/frpm_front.sv @@
// ============================================================================
// frpm_front - input word classifier
// Decides sample against evaluate, compares the memory total with the limit,
// tracks the poll interval and the previous fault count, and forms the delta.
// ============================================================================
module frpm_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [frpm_pkg::MEM_KB_W-1:0]      req_mem_free_kb,
   input  logic [frpm_pkg::MEM_KB_W-1:0]      req_buffers_kb,
   input  logic [frpm_pkg::MEM_KB_W-1:0]      req_cached_kb,
   input  logic                               req_mem_info_ok,
   input  logic [frpm_pkg::FAULT_W-1:0]       req_fault_reading,
   input  logic                               req_fault_reading_ok,
   input  logic [frpm_pkg::LIMIT_W-1:0]       free_mem_limit,
   input  frpm_pkg::frpm_qstat_type           queue_status,
   output logic                               push,
   output frpm_pkg::frpm_cmd_type             push_cmd
);

   logic                         slow_poll_ff, slow_poll_in;
   logic [frpm_pkg::FAULT_W-1:0] previous_reading_ff, previous_reading_in;
   logic [frpm_pkg::LIMIT_W-1:0] total;
   logic                         above;
   logic                         ring_write;

   assign req_ready = !queue_status.full;
   assign push      = req_valid && req_ready;

   assign total = frpm_pkg::LIMIT_W'(req_mem_free_kb) + frpm_pkg::LIMIT_W'(req_buffers_kb)
                + frpm_pkg::LIMIT_W'(req_cached_kb);
   // A failed memory report counts as just below the limit.
   assign above      = req_mem_info_ok && (total > free_mem_limit);
   assign ring_write = !req_mode && !above;

   always_comb begin
      slow_poll_in        = slow_poll_ff;
      previous_reading_in = previous_reading_ff;
      push_cmd.is_eval           = req_mode;
      push_cmd.ring_write        = ring_write;
      push_cmd.delta             = '0;
      push_cmd.poll_rate_changed = 1'b0;
      if (!req_mode) begin
         slow_poll_in               = above;
         push_cmd.poll_rate_changed = (slow_poll_ff != above);
         if (!above) begin
            if ((previous_reading_ff != '0) && req_fault_reading_ok) begin
               push_cmd.delta = $signed(req_fault_reading - previous_reading_ff);
            end
            previous_reading_in = req_fault_reading_ok ? req_fault_reading : '0;
         end
      end
      push_cmd.slow_polling = slow_poll_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_poll_ff        <= 1'b1;
         previous_reading_ff <= '0;
      end else if (push) begin
         slow_poll_ff        <= slow_poll_in;
         previous_reading_ff <= previous_reading_in;
      end
   end

endmodule

@@ src/frpm_queue.sv @@
// ============================================================================
// frpm_queue - short command queue
// Register queue that lets the front end keep accepting words while the
// back end is stalled by the result channel.
// ============================================================================
module frpm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  frpm_pkg::frpm_cmd_type   push_cmd,
   input  logic                     pop,
   output frpm_pkg::frpm_cmd_type   pop_cmd,
   output frpm_pkg::frpm_qstat_type status
);

   frpm_pkg::frpm_cmd_type         entry_ff [frpm_pkg::QUEUE_DEPTH];
   logic [frpm_pkg::Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [frpm_pkg::Q_PTR_W:0]     count_ff, count_in;
   logic                           do_push, do_pop;

   assign status.full  = (count_ff == (frpm_pkg::Q_PTR_W + 1)'(frpm_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_cmd      = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

@@ src/frpm_back.sv @@
// ============================================================================
// frpm_back - delta ring, running sum, average and level decision
// Pops commands from the queue, keeps the ring and its running sum, divides
// the sum by the window depth in a pipelined long division and drives the
// result register.
// ============================================================================
module frpm_back #(
   parameter int WINDOW_DEPTH = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  frpm_pkg::frpm_cmd_type             pop_cmd,
   input  frpm_pkg::frpm_qstat_type           queue_status,
   output logic                               pop,
   input  frpm_pkg::frpm_thresh_type          thresholds,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_level,
   output logic                               rsp_level_changed,
   output logic                               rsp_slow_polling,
   output logic                               rsp_poll_rate_changed,
   output logic signed [frpm_pkg::AVG_W-1:0]  rsp_average_faults
);

   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = frpm_pkg::FAULT_W + SLOT_W;
   localparam int REM_W  = SLOT_W + 1;
   localparam int STEPS  = 8;
   localparam int NUM_ST = (SUM_W + STEPS - 1) / STEPS;
   localparam int WORK_W = NUM_ST * STEPS;
   localparam logic [REM_W-1:0]  DIVISOR   = REM_W'(WINDOW_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

   typedef struct packed {
      logic              valid;
      logic              is_eval;
      logic              slow_polling;
      logic              poll_rate_changed;
      logic              neg;
      logic [REM_W-1:0]  rem;
      logic [WORK_W-1:0] work;
   } div_type;

   typedef struct packed {
      logic                              valid;
      logic                              is_eval;
      logic                              slow_polling;
      logic                              poll_rate_changed;
      logic signed [frpm_pkg::AVG_W-1:0] avg;
   } avg_type;

   logic                              advance;
   logic signed [frpm_pkg::FAULT_W-1:0] ring_ff [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0]           ring_valid_ff;
   logic signed [frpm_pkg::FAULT_W-1:0] old_data_ff;
   logic                              old_valid_ff;
   logic signed [frpm_pkg::FAULT_W-1:0] old_entry;
   logic [SLOT_W-1:0]                 write_slot_ff, write_slot_in;
   logic signed [SUM_W-1:0]           running_sum_ff, running_sum_in;
   logic                              do_write;
   div_type                           stage_ff [NUM_ST+1];
   div_type                           stage_in [NUM_ST+1];
   avg_type                           avg_ff, avg_in;
   frpm_pkg::frpm_level_type          current_level_ff, current_level_in;
   frpm_pkg::frpm_level_type          new_level;
   logic                              rsp_valid_ff, rsp_valid_in;
   frpm_pkg::frpm_level_type          rsp_level_ff;
   logic                              rsp_level_changed_ff, rsp_slow_polling_ff;
   logic                              rsp_poll_rate_changed_ff;
   logic signed [frpm_pkg::AVG_W-1:0] rsp_average_faults_ff;
   logic [SUM_W-1:0]                  magnitude;

   // The whole back pipeline moves as one when the result register is free.
   assign advance  = !rsp_valid_ff || rsp_ready;
   assign pop      = advance && !queue_status.empty;
   assign do_write = pop && pop_cmd.ring_write;

   // ---------------- ring, slot and running sum ----------------
   assign old_entry = old_valid_ff ? old_data_ff : '0;

   always_comb begin
      write_slot_in  = write_slot_ff;
      running_sum_in = running_sum_ff;
      if (do_write) begin
         write_slot_in  = (write_slot_ff == LAST_SLOT) ? '0 : write_slot_ff + 1'b1;
         running_sum_in = running_sum_ff - SUM_W'(old_entry) + SUM_W'(pop_cmd.delta);
      end
   end

   // The entry that the next write replaces is read into a register ahead of that write.
   always_ff @(posedge clock) begin
      if (do_write) begin
         ring_ff[write_slot_ff] <= pop_cmd.delta;
      end
      old_data_ff <= ring_ff[write_slot_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff  <= '0;
         old_valid_ff   <= 1'b0;
         write_slot_ff  <= '0;
         running_sum_ff <= '0;
      end else begin
         if (do_write) ring_valid_ff[write_slot_ff] <= 1'b1;
         old_valid_ff   <= ring_valid_ff[write_slot_in];
         write_slot_ff  <= write_slot_in;
         running_sum_ff <= running_sum_in;
      end
   end

   // ---------------- pipelined long division by the depth ----------------
   assign magnitude = running_sum_ff[SUM_W-1] ? SUM_W'(-running_sum_ff)
                                              : SUM_W'(running_sum_ff);

   always_comb begin
      stage_in[0].valid             = pop;
      stage_in[0].is_eval           = pop_cmd.is_eval;
      stage_in[0].slow_polling      = pop_cmd.slow_polling;
      stage_in[0].poll_rate_changed = pop_cmd.poll_rate_changed;
      stage_in[0].neg               = running_sum_ff[SUM_W-1];
      stage_in[0].rem               = '0;
      stage_in[0].work              = WORK_W'(magnitude);
   end

   for (genvar g = 0; g < NUM_ST; g++) begin : g_div
      always_comb begin
         div_type          t;
         logic [REM_W-1:0] r;
         t = stage_ff[g];
         for (int s = 0; s < STEPS; s++) begin
            r      = {t.rem[REM_W-2:0], t.work[WORK_W-1]};
            t.work = {t.work[WORK_W-2:0], 1'b0};
            if (r >= DIVISOR) begin
               r         = r - DIVISOR;
               t.work[0] = 1'b1;
            end
            t.rem = r;
         end
         stage_in[g+1] = t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NUM_ST; k++) begin
            stage_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         for (int k = 0; k <= NUM_ST; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // ---------------- sign restore ----------------
   always_comb begin
      logic [frpm_pkg::AVG_W-1:0] q;
      q = stage_ff[NUM_ST].work[frpm_pkg::AVG_W-1:0];
      avg_in.valid             = stage_ff[NUM_ST].valid;
      avg_in.is_eval           = stage_ff[NUM_ST].is_eval;
      avg_in.slow_polling      = stage_ff[NUM_ST].slow_polling;
      avg_in.poll_rate_changed = stage_ff[NUM_ST].poll_rate_changed;
      avg_in.avg               = '0;
      if (stage_ff[NUM_ST].is_eval) begin
         avg_in.avg = stage_ff[NUM_ST].neg ? $signed(-q) : $signed(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff.valid <= 1'b0;
      end else if (advance) begin
         avg_ff <= avg_in;
      end
   end

   // ---------------- level decision and result register ----------------
   always_comb begin
      if (avg_ff.avg > $signed({16'b0, thresholds.critical})) begin
         new_level = frpm_pkg::LEVEL_CRITICAL;
      end else if (avg_ff.avg > $signed({16'b0, thresholds.very_low})) begin
         new_level = frpm_pkg::LEVEL_VERY_LOW;
      end else if (avg_ff.avg > $signed({16'b0, thresholds.low})) begin
         new_level = frpm_pkg::LEVEL_LOW;
      end else begin
         new_level = frpm_pkg::LEVEL_NORMAL;
      end
      current_level_in = current_level_ff;
      if (advance && avg_ff.valid && avg_ff.is_eval) begin
         current_level_in = new_level;
      end
      rsp_valid_in = advance ? avg_ff.valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance && avg_ff.valid) begin
         rsp_level_ff             <= current_level_in;
         rsp_level_changed_ff     <= avg_ff.is_eval && (new_level != current_level_ff);
         rsp_slow_polling_ff      <= avg_ff.slow_polling;
         rsp_poll_rate_changed_ff <= avg_ff.poll_rate_changed;
         rsp_average_faults_ff    <= avg_ff.avg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         current_level_ff <= frpm_pkg::LEVEL_UNKNOWN;
      end else begin
         rsp_valid_ff     <= rsp_valid_in;
         current_level_ff <= current_level_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_level             = rsp_level_ff;
   assign rsp_level_changed     = rsp_level_changed_ff;
   assign rsp_slow_polling      = rsp_slow_polling_ff;
   assign rsp_poll_rate_changed = rsp_poll_rate_changed_ff;
   assign rsp_average_faults    = rsp_average_faults_ff;

   // ---------------- assertions ----------------
   a_changed_level_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_level_changed_ff |-> rsp_level_ff != frpm_pkg::LEVEL_UNKNOWN)
      else $error("level change reported toward the unknown level");

   a_one_kind_of_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_level_changed_ff && rsp_poll_rate_changed_ff))
      else $error("one word reports both a level and a poll change");

   a_sample_average_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_poll_rate_changed_ff |-> rsp_average_faults_ff == '0)
      else $error("sample word carries a nonzero average");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      write_slot_ff <= LAST_SLOT)
      else $error("ring slot beyond the window");

   a_level_follows_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_level_changed_ff && $rose(rsp_valid_ff)
      |-> rsp_level_ff == current_level_ff)
      else $error("reported level differs from the stored level");

endmodule
